[design/ohi_pkg.sv]
// ----------------------------------------------------------------------------
// ohi_pkg
// shared constants, codes, types and modular helpers for the hash insert block
// ----------------------------------------------------------------------------
package ohi_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);

  localparam int KEY_W      = 40;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int IDX_W      = 4;
  localparam int OUT_SLOT_W = 4;
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 2;
  localparam int DATA_W     = 32;

  localparam int NIB_W      = 4;
  localparam int NIB_RANGE  = 1 << NIB_W;
  localparam int NIB_CNT    = KEY_W / NIB_W;
  localparam int NCNT_W     = $clog2(NIB_CNT);
  localparam int RED_W      = SLOT_W + NIB_W;
  localparam int DH_MOD     = 7;
  localparam int DH_W       = 3;
  localparam int RD_W       = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OCCUPIED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

  localparam logic [ADDR_W-1:0] REG_PROBE_MODE = 2'd0;

  typedef struct packed {
    logic              clear;
    logic              wr_en;
    logic              rd_en;
    logic [SLOT_W-1:0] addr;
  } tbl_ctl_t;

  typedef struct packed {
    logic              done;
    logic [SLOT_W-1:0] home;
    logic [DH_W-1:0]   dstep;
  } hash_res_t;

  // v mod m for v < 16*m
  function automatic logic [RED_W-1:0] nib_reduce(input logic [RED_W-1:0] v,
                                                  input logic [RED_W-1:0] m);
    logic [RED_W-1:0] res;
    logic [RED_W-1:0] prod;
    res  = v;
    prod = '0;
    for (int q = 1; q < NIB_RANGE; q++) begin
      prod = RED_W'(q) * m;
      if (v >= prod) begin
        res = v - prod;
      end
    end
    return res;
  endfunction

  // (a + b) mod TABLE_SIZE for a, b below TABLE_SIZE
  function automatic logic [SLOT_W-1:0] add_mod(input logic [SLOT_W-1:0] a,
                                               input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SLOT_W+1)'(TABLE_SIZE)) begin
      s = s - (SLOT_W+1)'(TABLE_SIZE);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage

[design/ohi_residue.sv]
// ----------------------------------------------------------------------------
// ohi_residue
// nibble-serial reduction of a key to its home slot and double-hash step
// ----------------------------------------------------------------------------
module ohi_residue import ohi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output hash_res_t        res
);

  logic              busy;
  logic              done;
  logic [NCNT_W-1:0] cnt;
  logic [KEY_W-1:0]  sh;
  logic [SLOT_W-1:0] rn;
  logic [DH_W-1:0]   r7;

  logic [NIB_W-1:0]  nib;
  logic [RED_W-1:0]  rn_full;
  logic [RED_W-1:0]  r7_full;

  assign nib     = sh[KEY_W-1 -: NIB_W];
  assign rn_full = nib_reduce({rn, nib}, RED_W'(TABLE_SIZE));
  assign r7_full = nib_reduce(RED_W'({r7, nib}), RED_W'(DH_MOD));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= NCNT_W'(NIB_CNT - 1);
        sh   <= key;
        rn   <= '0;
        r7   <= '0;
      end else if (busy) begin
        rn  <= rn_full[SLOT_W-1:0];
        r7  <= r7_full[DH_W-1:0];
        sh  <= sh << NIB_W;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign res.done  = done;
  assign res.home  = rn;
  assign res.dstep = DH_W'(DH_MOD) - r7;

endmodule

[design/ohi_table.sv]
// ----------------------------------------------------------------------------
// ohi_table
// slot valid flags and key storage with one registered read port
// ----------------------------------------------------------------------------
module ohi_table import ohi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  tbl_ctl_t         ctl,
  input  logic [KEY_W-1:0] wr_key,
  output logic             chk_valid,
  output logic             rd_valid,
  output logic [KEY_W-1:0] rd_key
);

  logic [TABLE_SIZE-1:0] valid;
  logic [KEY_W-1:0]      keys [TABLE_SIZE];

  assign chk_valid = valid[ctl.addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clear) begin
      valid <= '0;
    end else if (ctl.wr_en) begin
      valid[ctl.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      keys[ctl.addr] <= wr_key;
    end
    if (ctl.rd_en) begin
      rd_key   <= keys[ctl.addr];
      rd_valid <= valid[ctl.addr];
    end
  end

endmodule

[design/open_addressing_hash_insert.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_insert
// open-addressing hash table with linear, quadratic or double-hash probing
// ----------------------------------------------------------------------------
// requests come in on in_valid/in_ready with func, key and slot_index; one
// result per request leaves on out_valid/out_ready with status, slot, value.
// probe_mode is written over the apb port at offset 0; the user must write it
// only while the block is idle, which the block itself does not enforce.
// in_ready is high only when the sequencer is idle; a finished result sits in
// the output register, so the next request can be taken while it waits.
// insert: nibble-serial key reduction (home slot and double-hash step), then
// one slot probed per cycle, up to TABLE_SIZE probes, then the output load.
// read: through the registered key store read port (states S_READ, S_RDOUT).
// clear and unused codes: result set on accept, then straight to S_DONE.
// reset empties all slots and sets linear probing; stored keys are not wiped.
// if out_ready stays low the sequencer holds its result and stops taking
// requests until the output register frees up.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert import ohi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     func,
  input  logic [KEY_W-1:0]      key,
  input  logic [IDX_W-1:0]      slot_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [OUT_SLOT_W-1:0] slot,
  output logic [KEY_W-1:0]      value,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RDOUT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state;
  logic [MODE_W-1:0]   probe_mode;
  logic [KEY_W-1:0]    key_r;
  logic [SLOT_W-1:0]   idx_r;
  logic [SLOT_W-1:0]   pos;
  logic [SLOT_W-1:0]   inc;
  logic [SLOT_W-1:0]   pcnt;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [KEY_W-1:0]    res_value;

  logic                accept;
  logic                out_load;
  logic                cfg_wr;
  logic [RD_W-1:0]     idx_red;
  tbl_ctl_t            ctl;
  hash_res_t           hres;
  logic                chk_valid;
  logic                rd_valid;
  logic [KEY_W-1:0]    rd_key;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_PROBE_MODE);
  assign prdata = (paddr == REG_PROBE_MODE) ? DATA_W'(probe_mode) : '0;

  always_comb begin
    idx_red = RD_W'(slot_index);
    if (idx_red >= RD_W'(TABLE_SIZE)) begin
      idx_red = idx_red - RD_W'(TABLE_SIZE);
    end
  end

  assign ctl.clear = accept && (func == FUNC_CLEAR);
  assign ctl.wr_en = (state == S_PROBE) && !chk_valid;
  assign ctl.rd_en = (state == S_READ);
  assign ctl.addr  = (state == S_READ) ? idx_r : pos;

  ohi_residue u_residue (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (func == FUNC_INSERT)),
    .key   (key),
    .res   (hres)
  );

  ohi_table u_table (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .wr_key    (key_r),
    .chk_valid (chk_valid),
    .rd_valid  (rd_valid),
    .rd_key    (rd_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      probe_mode <= MODE_LINEAR;
    end else begin
      if (cfg_wr) begin
        probe_mode <= pwdata[MODE_W-1:0];
      end

      if (out_load) begin
        out_valid <= 1'b1;
        status    <= res_status;
        slot      <= OUT_SLOT_W'(res_slot);
        value     <= res_value;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            key_r <= key;
            idx_r <= idx_red[SLOT_W-1:0];
            case (func)
              FUNC_INSERT: begin
                state <= S_HASH;
              end
              FUNC_READ: begin
                state <= S_READ;
              end
              FUNC_CLEAR: begin
                res_status <= ST_CLEARED;
                res_slot   <= '0;
                res_value  <= '0;
                state      <= S_DONE;
              end
              default: begin
                res_status <= ST_EMPTY;
                res_slot   <= '0;
                res_value  <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_HASH: begin
          if (hres.done) begin
            pos   <= hres.home;
            pcnt  <= '0;
            inc   <= (probe_mode == MODE_DOUBLE) ? SLOT_W'(hres.dstep) : SLOT_W'(1);
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (!chk_valid) begin
            res_status <= ST_INSERTED;
            res_slot   <= pos;
            res_value  <= key_r;
            state      <= S_DONE;
          end else if (pcnt == SLOT_W'(TABLE_SIZE - 1)) begin
            res_status <= ST_FULL;
            res_slot   <= '0;
            res_value  <= '0;
            state      <= S_DONE;
          end else begin
            pos  <= add_mod(pos, inc);
            pcnt <= pcnt + 1'b1;
            if (probe_mode == MODE_QUAD) begin
              inc <= add_mod(inc, SLOT_W'(2));
            end
          end
        end
        S_READ: begin
          state <= S_RDOUT;
        end
        S_RDOUT: begin
          res_status <= rd_valid ? ST_OCCUPIED : ST_EMPTY;
          res_slot   <= idx_r;
          res_value  <= rd_valid ? rd_key : '0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> (state == S_PROBE) && !chk_valid)
    else $error("write to an occupied slot");

  a_hash_in_seq: assert property (@(posedge clk) disable iff (rst)
    hres.done |-> (state == S_HASH))
    else $error("key reduction finished outside hash phase");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_FULL) || (status == ST_CLEARED)) |->
      (slot == '0) && (value == '0))
    else $error("full or cleared result carries data");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !out_valid |=> out_valid && (state == S_IDLE))
    else $error("finished result not moved to output register");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// randomized check of the open-addressing hash table against a slot tracker
// ----------------------------------------------------------------------------
// a directed run fills the table through one collision chain, overflows it,
// reads it back and clears it. Random phases then run in every probe mode,
// with colliding, repeated and extreme keys. Each accepted request is applied
// to a private copy of the table, and each result is checked against the
// oldest predicted outcome. Both handshakes stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import ohi_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int STRIDE_BASE  = 7;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 80;
  localparam int PHASES       = 5;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [KEY_W-1:0]      value;
  } outcome_t;

  class hash_slots_tracker;
    logic [KEY_W-1:0]  stored_keys [TABLE_SIZE];
    bit                occupied [TABLE_SIZE];
    logic [MODE_W-1:0] mode = MODE_LINEAR;
    outcome_t          expected_outcomes [$];
    int                mismatches = 0;

    function void set_mode(input logic [MODE_W-1:0] m);
      mode = m;
    endfunction

    function int unsigned probe_slot(input logic [KEY_W-1:0] k, input int unsigned i);
      longint unsigned kk;
      longint unsigned home;
      longint unsigned step;
      kk   = k;
      home = kk % TABLE_SIZE;
      case (mode)
        MODE_QUAD:   step = i * i;
        MODE_DOUBLE: step = i * (STRIDE_BASE - kk % STRIDE_BASE);
        default:     step = i;
      endcase
      return (home + step) % TABLE_SIZE;
    endfunction

    function void note_request(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                               input logic [IDX_W-1:0] idx);
      outcome_t    o;
      int unsigned p;
      o.status = ST_EMPTY;
      o.slot   = '0;
      o.value  = '0;
      case (f)
        FUNC_INSERT: begin
          o.status = ST_FULL;
          for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
            p = probe_slot(k, i);
            if (!occupied[p]) begin
              occupied[p]    = 1'b1;
              stored_keys[p] = k;
              o.status = ST_INSERTED;
              o.slot   = OUT_SLOT_W'(p);
              o.value  = k;
              break;
            end
          end
        end
        FUNC_READ: begin
          p = idx % TABLE_SIZE;
          o.slot = OUT_SLOT_W'(p);
          if (occupied[p]) begin
            o.status = ST_OCCUPIED;
            o.value  = stored_keys[p];
          end
        end
        FUNC_CLEAR: begin
          foreach (occupied[s]) occupied[s] = 1'b0;
          o.status = ST_CLEARED;
        end
        default: ;
      endcase
      expected_outcomes.push_back(o);
    endfunction

    function void flag(input string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void check_result(input logic [STATUS_W-1:0] st, input logic [OUT_SLOT_W-1:0] sl,
                               input logic [KEY_W-1:0] val);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        flag($sformatf("unexpected result: status %0d slot %0d value %h", st, sl, val));
        return;
      end
      want = expected_outcomes.pop_front();
      if (st !== want.status || sl !== want.slot || val !== want.value) begin
        flag($sformatf("mismatch: expected status %0d slot %0d value %h, got %0d %0d %h",
                       want.status, want.slot, want.value, st, sl, val));
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     func = '0;
  logic [KEY_W-1:0]      key = '0;
  logic [IDX_W-1:0]      slot_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [OUT_SLOT_W-1:0] slot;
  logic [KEY_W-1:0]      value;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  hash_slots_tracker tracker = new();
  int                idle_odds = 0;
  int                quiet_cycles = 0;
  logic [SLOT_W-1:0] hot_home = '0;
  logic [KEY_W-1:0]  last_key = '0;

  open_addressing_hash_insert uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                              input logic [IDX_W-1:0] idx);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    key        <= k;
    slot_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.expected_outcomes.size() != 0);
    @(posedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_mode(MODE_W'(data));
  endtask

  task automatic random_request();
    int                pick;
    logic [KEY_W-1:0]  k;
    logic [IDX_W-1:0]  idx;
    pick = $urandom_range(0, 99);
    k    = {8'($urandom), 32'($urandom)};
    idx  = IDX_W'($urandom);
    if (pick < 68) begin
      case ($urandom_range(0, 5))
        0: k[SLOT_W-1:0] = hot_home;
        1: k = last_key;
        2: k = ($urandom_range(0, 1) != 0) ? '1 : '0;
        3: k = KEY_W'($urandom_range(0, 63));
        default: ;
      endcase
      last_key = k;
      send_request(FUNC_INSERT, k, idx);
    end else if (pick < 95) begin
      send_request(FUNC_READ, k, idx);
    end else if (pick < 98) begin
      send_request(FUNC_CLEAR, k, idx);
    end else begin
      send_request(FUNC_NOP, k, idx);
    end
  endtask

  initial begin
    forever begin
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_request(func, key, slot_index);
      if (out_valid && out_ready) tracker.check_result(status, slot, value);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [MODE_W-1:0] phase_mode [PHASES];
    int                phase_odds [PHASES];
    logic [KEY_W-1:0]  k;
    phase_mode = '{MODE_QUAD, MODE_DOUBLE, MODE_SPARE, MODE_LINEAR, MODE_DOUBLE};
    phase_odds = '{4, 3, 0, 2, 0};
    k = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_write(REG_PROBE_MODE, DATA_W'(MODE_LINEAR));
    idle_odds = 3;

    send_request(FUNC_CLEAR, '0, '0);
    send_request(FUNC_NOP, '0, '0);
    send_request(FUNC_INSERT, '0, '0);
    send_request(FUNC_INSERT, '1, '1);
    // collision chain on home slot 5, with one repeated key, fills the table
    for (int j = 0; j < TABLE_SIZE - 2; j++) begin
      if (j != 3) k = {8'($urandom), 28'($urandom), 4'h5};
      send_request(FUNC_INSERT, k, '0);
    end
    send_request(FUNC_INSERT, k, '0);
    send_request(FUNC_READ, '0, '0);
    send_request(FUNC_READ, '0, '1);
    send_request(FUNC_READ, '0, IDX_W'(7));
    send_request(FUNC_CLEAR, '1, '1);
    send_request(FUNC_READ, '0, IDX_W'(3));
    send_request(FUNC_NOP, '1, '1);

    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      reg_write(REG_PROBE_MODE, DATA_W'(phase_mode[p]));
      idle_odds = phase_odds[p];
      hot_home  = SLOT_W'($urandom_range(0, TABLE_SIZE - 1));
      repeat (PHASE_ITEMS) random_request();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
